### rtl/dlrr_pkg.sv
// Shared constants, types and helpers for the dirty-line round-robin flusher.
// No dependencies; imported by every other file of the block except dlrr_ram.
package dlrr_pkg;

  localparam int BOARDS    = 8;
  localparam int DIGITS    = 8;
  localparam int LINE_W    = 64;
  localparam int BOARD_W   = 3;
  localparam int MASK_W    = 8;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = (BOARDS > 1) ? $clog2(BOARDS) : 1;
  localparam int TRY_W     = (BOARDS > 1) ? $clog2(BOARDS) : 1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DONE  = 2'd2;

  localparam logic [MASK_W-1:0] FIRST_DIGIT_BIT = 8'h80;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [LINE_W-1:0] wdata;
  } ram_req_t;

  function automatic logic [IDX_W-1:0] next_board(logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] n;
    if (32'(b) == BOARDS - 1) n = '0;
    else n = b + 1'b1;
    return n;
  endfunction

  function automatic logic [LINE_W-1:0] merge_line(logic [LINE_W-1:0] old_line,
                                                   logic [MASK_W-1:0] mask,
                                                   logic [LINE_W-1:0] data);
    logic [LINE_W-1:0] line;
    line = old_line;
    for (int d = 0; d < DIGITS && d < 8; d++) begin
      if ((mask & (FIRST_DIGIT_BIT >> d)) != '0) begin
        line[8*d +: 8] = data[8*d +: 8];
      end
    end
    return line;
  endfunction

endpackage

### rtl/dlrr_if.sv
// Valid/ready channel interfaces for the flusher's command and send streams.
// Depends on dlrr_pkg for field widths.
interface dlrr_in_if import dlrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [BOARD_W-1:0] board_index;
  logic [MASK_W-1:0]  digit_mask;
  logic [LINE_W-1:0]  digit_data;

  modport source (output valid, cmd, board_index, digit_mask, digit_data, input ready);
  modport sink   (input valid, cmd, board_index, digit_mask, digit_data, output ready);
endinterface

interface dlrr_out_if import dlrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BOARD_W-1:0] sent_board;
  logic [LINE_W-1:0]  sent_line;

  modport source (output valid, sent_board, sent_line, input ready);
  modport sink   (input valid, sent_board, sent_line, output ready);
endinterface

### rtl/dlrr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module dlrr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   re,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/dlrr_ctrl.sv
// Sequencer of the flusher: command decode, masked line merge, round-robin scan,
// changed/valid flags and the send output register. Depends on dlrr_pkg, dlrr_if.
module dlrr_ctrl import dlrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dlrr_in_if.sink           in_ch,
  dlrr_out_if.source        out_ch,
  output ram_req_t          ram_req,
  input  logic [LINE_W-1:0] ram_rdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_MERGE, ST_SCAN, ST_FETCH} state_t;

  state_t             state_r, state_nxt;
  logic [BOARDS-1:0]  chg_r, chg_nxt;
  logic [BOARDS-1:0]  vld_r, vld_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic               busy_r, busy_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [TRY_W-1:0]   tries_r, tries_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [LINE_W-1:0]  data_r, data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BOARD_W-1:0] out_board_r, out_board_nxt;
  logic [LINE_W-1:0]  out_line_r, out_line_nxt;
  logic [LINE_W-1:0]  old_line;

  assign old_line = vld_r[idx_r] ? ram_rdata : '0;

  always_comb begin
    state_nxt     = state_r;
    chg_nxt       = chg_r;
    vld_nxt       = vld_r;
    last_nxt      = last_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    tries_nxt     = tries_r;
    mask_nxt      = mask_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    out_board_nxt = out_board_r;
    out_line_nxt  = out_line_r;
    ram_req       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.cmd)
            CMD_WRITE: begin
              if (32'(in_ch.board_index) < BOARDS) begin
                idx_nxt      = IDX_W'(in_ch.board_index);
                mask_nxt     = in_ch.digit_mask;
                data_nxt     = in_ch.digit_data;
                ram_req.re   = 1'b1;
                ram_req.addr = IDX_W'(in_ch.board_index);
                state_nxt    = ST_MERGE;
              end
            end
            CMD_TICK: begin
              if (!busy_r) begin
                idx_nxt   = next_board(last_r);
                tries_nxt = '0;
                state_nxt = ST_SCAN;
              end
            end
            CMD_DONE: busy_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        ram_req.we     = 1'b1;
        ram_req.addr   = idx_r;
        ram_req.wdata  = merge_line(old_line, mask_r, data_r);
        vld_nxt[idx_r] = 1'b1;
        chg_nxt[idx_r] = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        if (chg_r[idx_r]) begin
          ram_req.re   = 1'b1;
          ram_req.addr = idx_r;
          state_nxt    = ST_FETCH;
        end else if (32'(tries_r) == BOARDS - 1) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = next_board(idx_r);
          tries_nxt = tries_r + 1'b1;
        end
      end
      ST_FETCH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_board_nxt  = BOARD_W'(idx_r);
          out_line_nxt   = old_line;
          chg_nxt[idx_r] = 1'b0;
          last_nxt       = idx_r;
          busy_nxt       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chg_r       <= '0;
      vld_r       <= '0;
      last_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chg_r       <= chg_nxt;
      vld_r       <= vld_nxt;
      last_r      <= last_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    tries_r     <= tries_nxt;
    mask_r      <= mask_nxt;
    data_r      <= data_nxt;
    out_board_r <= out_board_nxt;
    out_line_r  <= out_line_nxt;
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sent_board = out_board_r;
  assign out_ch.sent_line  = out_line_r;

endmodule

### rtl/dirty_line_round_robin_flusher_unit.sv
// Dirty-line round-robin flusher, top level.
// Usage:
//   in_ch  (sink)  : commands. cmd 0 writes the digits of one board's line
//                    selected by digit_mask (bit 7 = digit 0) and marks it changed;
//                    cmd 1 is a flush tick; cmd 2 reports the send finished.
//   out_ch (source): one line to send (sent_board, sent_line), from a tick only.
// A transfer happens when valid and ready are both high at a clock edge.
// Sequence:
//   write     : RAM read, then merge and write back.
//   tick      : ignored when busy; otherwise an accept step, a scan of one
//               board per cycle (up to BOARDS boards) and a fetch of the found line.
//   send done : clears busy. ready is high only while the sequencer is idle.
// The scan shares the single RAM port with the write merge. The result sits in an
// output register; a stalled receiver holds it, and a later tick that finds a line
// waits in the fetch step until it drains.
// Reset (rst_n low, synchronous) clears all changed flags, line valid bits,
// busy and the last-sent board; unwritten lines read as zero, so no RAM
// clearing pass is needed.
module dirty_line_round_robin_flusher_unit import dlrr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dlrr_in_if.sink    in_ch,
  dlrr_out_if.source out_ch
);

  ram_req_t          ram_req;
  logic [LINE_W-1:0] ram_rdata;

  dlrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  dlrr_ram #(
    .WIDTH (LINE_W),
    .DEPTH (BOARDS)
  ) u_line_ram (
    .clk   (clk),
    .re    (ram_req.re),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.re && ram_req.we))
    else $error("line RAM read and written in the same cycle");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> ($past(ram_req.re) && $past(ram_req.addr) == ram_req.addr))
    else $error("line write-back without a read of the same board");

  a_write_holds_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_WRITE
     && 32'(in_ch.board_index) < BOARDS) |=> !in_ch.ready)
    else $error("ready high during a line merge");
`endif

endmodule

### tb/tb_dirty_line_round_robin_flusher_unit.sv
// Testbench for dirty_line_round_robin_flusher_unit: directed and random command streams,
// checked against a cycle-free model of the line store, changed flags and round-robin send.
// Depends on rtl/dlrr_pkg.sv, rtl/dlrr_if.sv and the top-level RTL.
module tb_dirty_line_round_robin_flusher_unit;
  import dlrr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [BOARD_W-1:0] board;
    logic [LINE_W-1:0]  line;
  } sent_line_t;

  logic clk = 1'b0;
  logic rst_n;

  dlrr_in_if  in_ch();
  dlrr_out_if out_ch();

  dirty_line_round_robin_flusher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [LINE_W-1:0]  board_lines [BOARDS];
  logic               board_dirty [BOARDS];
  logic [BOARD_W-1:0] last_board;
  logic               send_busy;
  sent_line_t         pending_sends[$];
  sent_line_t         oldest_send;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int quiet_cycles;
  int errors;
  int commands_sent;
  int lines_sent;

  function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [BOARD_W-1:0] board,
                                        logic [MASK_W-1:0] mask, logic [LINE_W-1:0] data);
    logic [LINE_W-1:0]  line;
    logic [BOARD_W-1:0] probe;
    sent_line_t         sent;
    case (cmd)
      CMD_WRITE: begin
        if (int'(board) < BOARDS) begin
          line = board_lines[board];
          for (int d = 0; d < DIGITS && d < 8; d++) begin
            if (mask[MASK_W-1-d]) line[8*d +: 8] = data[8*d +: 8];
          end
          board_lines[board] = line;
          board_dirty[board] = 1'b1;
        end
      end
      CMD_TICK: begin
        if (!send_busy) begin
          probe = last_board;
          for (int k = 0; k < BOARDS; k++) begin
            probe = (int'(probe) == BOARDS - 1) ? '0 : probe + 1'b1;
            if (board_dirty[probe]) begin
              sent.board = probe;
              sent.line = board_lines[probe];
              pending_sends.push_back(sent);
              board_dirty[probe] = 1'b0;
              last_board = probe;
              send_busy = 1'b1;
              break;
            end
          end
        end
      end
      CMD_DONE: send_busy = 1'b0;
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [BOARD_W-1:0] board,
                           logic [MASK_W-1:0] mask, logic [LINE_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.board_index <= board;
    in_ch.digit_mask <= mask;
    in_ch.digit_data <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_command(cmd, board, mask, data);
    if (cmd != CMD_UNUSED) commands_sent++;
  endtask

  function automatic logic [LINE_W-1:0] random_line();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_random(logic [BOARD_W-1:0] board);
    send_item(CMD_WRITE, board, MASK_W'($urandom_range(255)), random_line());
  endtask

  task automatic test_idle_commands();
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_DONE, '0, '0, '0);
    send_item(CMD_UNUSED, 3'd1, 8'hFF, '1);
    send_item(CMD_TICK, '0, '0, '0);
  endtask

  task automatic test_masked_writes();
    send_item(CMD_WRITE, 3'd0, 8'hFF, '1);
    send_item(CMD_WRITE, 3'd0, 8'h00, '0);
    send_item(CMD_WRITE, 3'd7, 8'h80, '1);
    send_item(CMD_WRITE, 3'd5, 8'h01, 64'hA5A5_A5A5_A5A5_A5A5);
    send_item(CMD_WRITE, 3'd3, 8'hAA, random_line());
    send_item(CMD_WRITE, 3'd3, 8'h55, '0);
    repeat (5) begin
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_DONE, '0, '0, '0);
    end
  endtask

  task automatic test_busy_send();
    send_item(CMD_WRITE, 3'd2, 8'hFF, random_line());
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_WRITE, 3'd2, 8'h0F, random_line());
    send_item(CMD_DONE, '0, '0, '0);
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_DONE, '0, '0, '0);
  endtask

  task automatic test_receiver_stall();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (3) begin
      write_random(3'($urandom_range(7)));
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_DONE, '0, '0, '0);
    end
    write_random(3'($urandom_range(7)));
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_DONE, '0, '0, '0);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int target);
    int start;
    int bursts;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = commands_sent;
    while (commands_sent - start < target) begin
      if ($urandom_range(99) < 80) begin
        bursts = $urandom_range(3);
        repeat (bursts) write_random(3'($urandom_range(7)));
        send_item(CMD_TICK, '0, '0, '0);
        if ($urandom_range(3) == 0) send_item(CMD_TICK, '0, '0, '0);
        if ($urandom_range(3) == 0) write_random(3'($urandom_range(7)));
        send_item(CMD_DONE, '0, '0, '0);
      end else begin
        send_item(CMD_W'($urandom_range(3)), 3'($urandom_range(7)),
                  MASK_W'($urandom_range(255)), random_line());
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_sends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      lines_sent++;
      if (pending_sends.size() == 0) begin
        $error("sent_board: unexpected transfer, board %0d line %h",
               out_ch.sent_board, out_ch.sent_line);
        errors++;
      end else begin
        oldest_send = pending_sends.pop_front();
        if (out_ch.sent_board !== oldest_send.board) begin
          $error("sent_board: expected %0d, actual %0d", oldest_send.board,
                 out_ch.sent_board);
          errors++;
        end
        if (out_ch.sent_line !== oldest_send.line) begin
          $error("sent_line: expected %h, actual %h", oldest_send.line, out_ch.sent_line);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_WRITE;
    in_ch.board_index = '0;
    in_ch.digit_mask = '0;
    in_ch.digit_data = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    errors = 0;
    commands_sent = 0;
    lines_sent = 0;
    for (int b = 0; b < BOARDS; b++) begin
      board_lines[b] = '0;
      board_dirty[b] = 1'b0;
    end
    last_board = '0;
    send_busy = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_commands();
    test_masked_writes();
    test_busy_send();
    test_receiver_stall();
    test_random_traffic(21, 75, 300);
    test_random_traffic(75, 21, 300);
    test_random_traffic(0, 0, 300);
    drain_results();

    if (pending_sends.size() != 0) begin
      $error("sent_board: %0d expected transfers never arrived", pending_sends.size());
      errors++;
    end
    $display("Covered %0d commands and %0d sent lines: masked writes, busy ticks,",
             commands_sent, lines_sent);
    $display("round-robin wrap, ignored commands, three idle mixes and a long receiver stall.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### dirty_line_round_robin_flusher_unit.f
rtl/dlrr_pkg.sv
rtl/dlrr_if.sv
rtl/dlrr_ram.sv
rtl/dlrr_ctrl.sv
rtl/dirty_line_round_robin_flusher_unit.sv
tb/tb_dirty_line_round_robin_flusher_unit.sv
